FILE: hw/rtl/fdm_pkg.sv
package fdm_pkg;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] STATUS_NONE  = 2'd0;
   localparam logic [1:0] STATUS_MATCH = 2'd1;
   localparam logic [1:0] STATUS_END   = 2'd2;

   // directory entry markers
   localparam logic [7:0] END_MARK     = 8'h00;
   localparam logic [7:0] DELETED_MARK = 8'hE5;
   localparam logic [7:0] LFN_ATTR     = 8'h0F;
   localparam logic [7:0] VOLID_BIT    = 8'h08;

   // byte positions within a 32-byte entry
   localparam logic [4:0] POS_NAME_LAST = 5'd10;
   localparam logic [4:0] POS_ATTR      = 5'd11;
   localparam logic [4:0] POS_CLUS_HI0  = 5'd20;
   localparam logic [4:0] POS_CLUS_HI1  = 5'd21;
   localparam logic [4:0] POS_CLUS_LO0  = 5'd26;
   localparam logic [4:0] POS_CLUS_LO1  = 5'd27;
   localparam logic [4:0] POS_SIZE0     = 5'd28;
   localparam logic [4:0] POS_SIZE1     = 5'd29;
   localparam logic [4:0] POS_SIZE2     = 5'd30;
   localparam logic [4:0] POS_LAST      = 5'd31;

   localparam int unsigned NAME_CHARS = 11;

   // configuration register indexes
   localparam logic CSR_TARGET_NAME = 1'b0;
   localparam logic CSR_TARGET_EXT  = 1'b1;

   localparam logic [63:0] TARGET_NAME_RESET = 64'h2020202020202020;
   localparam logic [23:0] TARGET_EXT_RESET  = 24'h202020;

   typedef struct packed {
      logic        fire;
      logic [1:0]  status;
      logic [31:0] first_cluster;
      logic [31:0] entry_size;
   } fdm_result_type;

endpackage

FILE: hw/rtl/fdm_entry_parser.sv
module fdm_entry_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             dir_byte,
   input  logic                   restart,
   input  logic [63:0]            target_name,
   input  logic [23:0]            target_ext,
   output fdm_pkg::fdm_result_type result
);
   import fdm_pkg::*;

   logic [4:0]  byte_pos_ff, byte_pos_in;
   logic        name_equal_ff, name_equal_in;
   logic        skip_entry_ff, skip_entry_in;
   logic        search_done_ff, search_done_in;
   logic [15:0] cluster_high_ff, cluster_high_in;
   logic [15:0] cluster_low_ff, cluster_low_in;
   logic [31:0] size_ff, size_in;

   logic [4:0]  pos;
   logic        name_eq_cur;
   logic        skip_cur;
   logic        done_cur;
   logic [7:0]  tchar [NAME_CHARS];
   logic [7:0]  tchar_sel;
   logic [87:0] target_all;
   logic        is_end;
   logic        is_match;

   assign target_all = {target_name, target_ext};

   // restart clears position, skip and done and sets name-equal before the byte is taken
   assign pos         = restart ? 5'd0 : byte_pos_ff;
   assign name_eq_cur = restart ? 1'b1 : name_equal_ff;
   assign skip_cur    = restart ? 1'b0 : skip_entry_ff;
   assign done_cur    = restart ? 1'b0 : search_done_ff;

   always_comb begin
      for (int i = 0; i < NAME_CHARS; i++) begin
         tchar[i] = target_all[8*(NAME_CHARS-1-i) +: 8];
      end
      tchar_sel = 8'h00;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (pos == 5'(i)) tchar_sel = tchar[i];
      end
   end

   always_comb begin
      byte_pos_in     = pos;
      name_equal_in   = name_eq_cur;
      skip_entry_in   = skip_cur;
      search_done_in  = done_cur;
      cluster_high_in = cluster_high_ff;
      cluster_low_in  = cluster_low_ff;
      size_in         = size_ff;
      is_end          = 1'b0;
      is_match        = 1'b0;

      if (!done_cur) begin
         if (pos == 5'd0 && dir_byte == END_MARK) begin
            is_end         = 1'b1;
            search_done_in = 1'b1;
         end else begin
            if (pos == 5'd0 && dir_byte == DELETED_MARK) skip_entry_in = 1'b1;
            if (pos <= POS_NAME_LAST) begin
               if (dir_byte != tchar_sel) name_equal_in = 1'b0;
            end
            unique case (pos)
               POS_ATTR: begin
                  if (dir_byte == LFN_ATTR || (dir_byte & VOLID_BIT) != 8'h00)
                     skip_entry_in = 1'b1;
               end
               POS_CLUS_HI0: cluster_high_in[7:0]  = dir_byte;
               POS_CLUS_HI1: cluster_high_in[15:8] = dir_byte;
               POS_CLUS_LO0: cluster_low_in[7:0]   = dir_byte;
               POS_CLUS_LO1: cluster_low_in[15:8]  = dir_byte;
               POS_SIZE0:    size_in[7:0]          = dir_byte;
               POS_SIZE1:    size_in[15:8]         = dir_byte;
               POS_SIZE2:    size_in[23:16]        = dir_byte;
               POS_LAST:     size_in[31:24]        = dir_byte;
               default: ;
            endcase
            if (pos == POS_LAST) begin
               is_match       = name_equal_in && !skip_entry_in;
               search_done_in = is_match;
               byte_pos_in    = 5'd0;
               name_equal_in  = 1'b1;
               skip_entry_in  = 1'b0;
            end else begin
               byte_pos_in = pos + 5'd1;
            end
         end
      end
   end

   always_comb begin
      result.fire          = !done_cur && (is_end || pos == POS_LAST);
      result.status        = is_end ? STATUS_END : (is_match ? STATUS_MATCH : STATUS_NONE);
      result.first_cluster = is_match ? {cluster_high_ff, cluster_low_ff} : 32'd0;
      result.entry_size    = is_match ? size_in : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff    <= 5'd0;
         name_equal_ff  <= 1'b1;
         skip_entry_ff  <= 1'b0;
         search_done_ff <= 1'b0;
      end else if (step) begin
         byte_pos_ff    <= byte_pos_in;
         name_equal_ff  <= name_equal_in;
         skip_entry_ff  <= skip_entry_in;
         search_done_ff <= search_done_in;
      end
   end

   // cluster and size bytes are rewritten in every entry before use
   always_ff @(posedge clock) begin
      if (step) begin
         cluster_high_ff <= cluster_high_in;
         cluster_low_ff  <= cluster_low_in;
         size_ff         <= size_in;
      end
   end

endmodule

FILE: hw/rtl/fat_dir_entry_matcher.sv
// a result word passes the input stage register and the output register before rsp_tvalid
// throughput: one directory byte per cycle unless stalled, set by the single-pass parser
// an output register decouples the two sides, so bytes without a result keep flowing
// while a result waits; a byte that gives a result stalls until the waiting word is taken
// reset (synchronous, active high) clears position, skip flag, done and both pipeline
// valids, sets name-equal, and loads the target name and extension with spaces
module fat_dir_entry_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] dir_byte
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] first_cluster, [63:32] entry_size
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);
   import fdm_pkg::*;

   logic [63:0] target_name_ff;
   logic [23:0] target_ext_ff;

   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_restart_ff;

   logic        out_valid_ff;
   logic [1:0]  out_status_ff;
   logic [31:0] out_cluster_ff;
   logic [31:0] out_size_ff;

   fdm_result_type result;
   logic           advance;
   logic           req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_name_ff <= TARGET_NAME_RESET;
         target_ext_ff  <= TARGET_EXT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_NAME: target_name_ff <= csr_wdata;
            CSR_TARGET_EXT:  target_ext_ff  <= csr_wdata[23:0];
         endcase
      end
   end

   fdm_entry_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .dir_byte    (s1_byte_ff),
      .restart     (s1_restart_ff),
      .target_name (target_name_ff),
      .target_ext  (target_ext_ff),
      .result      (result)
   );

   // a byte without a result never waits on the output side
   assign advance    = s1_valid_ff && (!result.fire || !out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff    <= req_tdata;
         s1_restart_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.fire) begin
         out_status_ff  <= result.status;
         out_cluster_ff <= result.first_cluster;
         out_size_ff    <= result.entry_size;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_size_ff, out_cluster_ff};
   assign rsp_tuser  = out_status_ff;

`ifndef NO_ASSERTIONS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_NONE || rsp_tuser == STATUS_MATCH ||
                      rsp_tuser == STATUS_END))
      else $error("undefined result status");

   a_nonmatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STATUS_MATCH) |-> (rsp_tdata == 64'd0))
      else $error("cluster or size not cleared on non-match");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("stalled byte lost from input stage");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      (advance && result.fire) |-> (!out_valid_ff || rsp_tready))
      else $error("result overwrote a word still waiting");
`endif

endmodule
